### hdl/spd_pkg.sv
// Shared types, codes and constants of the sensor packet deframer.
package spd_pkg;

  // Configuration register indexes and widths
  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 1;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_WORD     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS = 1'd1;

  localparam logic [15:0] SYNC_WORD_RST = 16'hEF01;
  localparam logic [15:0] TIMEOUT_RST   = 16'd1000;

  localparam int BUF_BYTES_DEF = 64;

  // Frame layout: two start bytes, four address bytes, type, two length bytes
  localparam int HEADER_BYTES = 9;
  localparam int LEN_OFFSET   = 8;
  localparam int POS_HUNT     = 0;
  localparam int POS_CODE_LO  = 1;
  localparam int POS_ADDR_FST = 2;
  localparam int POS_ADDR_LST = 5;
  localparam int POS_TYPE     = 6;
  localparam int POS_LEN_HI   = 7;
  localparam int POS_LEN_LO   = 8;

  // Request kinds
  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  typedef enum logic [1:0] {
    EV_BODY    = 2'd0,
    EV_OK      = 2'd1,
    EV_BAD     = 2'd2,
    EV_TIMEOUT = 2'd3
  } event_t;

  // Frame holds and tick counter
  typedef struct packed {
    logic [7:0]  type_hold;
    logic [15:0] length_hold;
    logic [31:0] address_hold;
    logic [15:0] tick_count;
  } hold_t;

  // One result beat
  typedef struct packed {
    event_t      event_res;
    logic [7:0]  body_byte;
    logic [5:0]  body_index;
    logic [7:0]  frame_type;
    logic [15:0] frame_length;
    logic [31:0] frame_address;
  } res_beat_t;

endpackage

### hdl/spd_if.sv
// Request and result channel interfaces of the sensor packet deframer.
interface spd_req_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] rx_byte;

  modport source (output valid, output req_type, output rx_byte, input ready);
  modport sink   (input valid, input req_type, input rx_byte, output ready);
endinterface

interface spd_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  event_res;
  logic [7:0]  body_byte;
  logic [5:0]  body_index;
  logic [7:0]  frame_type;
  logic [15:0] frame_length;
  logic [31:0] frame_address;

  modport source (output valid, output event_res, output body_byte, output body_index,
                  output frame_type, output frame_length, output frame_address,
                  input ready);
  modport sink   (input valid, input event_res, input body_byte, input body_index,
                  input frame_type, input frame_length, input frame_address,
                  output ready);
endinterface

### hdl/spd_frame_step.sv
// Per-beat deframing step: next position, holds and result for one request.
module spd_frame_step
  import spd_pkg::*;
#(
  parameter int BUF_BYTES = BUF_BYTES_DEF,
  localparam int POS_W = $clog2(BUF_BYTES)
) (
  input  logic             req_type,
  input  logic [7:0]       rx_byte,
  input  logic [15:0]      sync_word,
  input  logic [15:0]      timeout_ticks,
  input  logic [POS_W-1:0] position,
  input  hold_t            hold,
  output logic [POS_W-1:0] position_next,
  output hold_t            hold_next,
  output res_beat_t        beat,
  output logic             beat_valid
);

  localparam logic [POS_W:0] OVF_POS = (POS_W+1)'(BUF_BYTES - HEADER_BYTES);

  logic [15:0]  tick_inc;
  logic [15:0]  body_pos;
  logic [15:0]  len_pos;
  logic [POS_W:0] pos_adv;
  logic         advance;
  logic         frame_end;

  assign tick_inc = (hold.tick_count == 16'hFFFF) ? hold.tick_count
                                                  : hold.tick_count + 16'd1;
  assign body_pos = 16'(position) - 16'(HEADER_BYTES);
  assign len_pos  = 16'(position) - 16'(LEN_OFFSET);
  assign pos_adv  = {1'b0, position} + (POS_W+1)'(1);

  always_comb begin
    hold_next       = hold;
    position_next   = position;
    beat_valid      = 1'b0;
    beat.event_res  = EV_BODY;
    beat.body_byte  = '0;
    beat.body_index = '0;
    advance         = 1'b0;
    frame_end       = 1'b0;

    if (req_type == REQ_TICK) begin
      hold_next.tick_count = tick_inc;
      if (tick_inc >= timeout_ticks) begin
        beat_valid     = 1'b1;
        beat.event_res = EV_TIMEOUT;
        frame_end      = 1'b1;
      end
    end else begin
      advance = 1'b1;
      case (position) inside
        POS_HUNT: begin
          // drop bytes until the high start byte shows up
          if (rx_byte != sync_word[15:8]) advance = 1'b0;
        end
        POS_CODE_LO: begin
          if (rx_byte != sync_word[7:0]) begin
            beat_valid     = 1'b1;
            beat.event_res = EV_BAD;
            frame_end      = 1'b1;
          end
        end
        [POS_ADDR_FST:POS_ADDR_LST]: begin
          hold_next.address_hold = {hold.address_hold[23:0], rx_byte};
        end
        POS_TYPE: begin
          hold_next.type_hold = rx_byte;
        end
        POS_LEN_HI: begin
          hold_next.length_hold = {rx_byte, 8'd0};
        end
        POS_LEN_LO: begin
          hold_next.length_hold = {hold.length_hold[15:8], rx_byte};
        end
        default: begin
          beat_valid      = 1'b1;
          beat.body_byte  = rx_byte;
          beat.body_index = body_pos[5:0];
          if (len_pos == hold.length_hold) begin
            beat.event_res = EV_OK;
            frame_end      = 1'b1;
          end
        end
      endcase

      if (advance && !frame_end) begin
        if (pos_adv >= OVF_POS) begin
          // overflow replaces any body beat of this byte
          beat_valid      = 1'b1;
          beat.event_res  = EV_BAD;
          beat.body_byte  = '0;
          beat.body_index = '0;
          frame_end       = 1'b1;
        end else begin
          position_next = pos_adv[POS_W-1:0];
        end
      end
    end

    if (frame_end) begin
      position_next        = '0;
      hold_next.tick_count = '0;
    end

    beat.frame_type    = hold_next.type_hold;
    beat.frame_length  = hold_next.length_hold;
    beat.frame_address = hold_next.address_hold;
  end

endmodule

### hdl/sensor_packet_deframer_unit.sv
// Top level of the sensor packet deframer: state, config and result register.
//
// Usage:
//   req carries one beat per received UART byte (req_type 0, rx_byte) or per
//   millisecond tick (req_type 1). res carries at most one beat per request:
//   a body byte with its index, frame ok (with the last body byte), bad
//   packet, or timeout, each with the current type, length and address.
//   cfg_we/cfg_index/cfg_data write sync_word (index 0) and timeout_ticks
//   (index 1); write only while the block is idle.
// Timing:
//   A request is decoded in the cycle it is accepted and its result beat
//   sits in the result register on the next cycle. Unless res is stalled,
//   a new request is taken every cycle; the single per-beat state update
//   (position, holds, tick counter) sets that rate of one beat per cycle.
// Reset (rst, synchronous):
//   Clear position to hunting, holds and tick counter to zero, load the
//   default start code 0xEF01 and a timeout of 1000 ticks. No clearing pass.
// Stall:
//   While res is stalled and holds a beat, req.ready drops; requests that
//   wait are neither lost nor reordered.
module sensor_packet_deframer_unit
  import spd_pkg::*;
#(
  parameter int BUF_BYTES = BUF_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  spd_req_if.sink              req,
  spd_res_if.source            res
);

  localparam int POS_W = $clog2(BUF_BYTES);
  localparam logic [POS_W:0] OVF_POS = (POS_W+1)'(BUF_BYTES - HEADER_BYTES);

  // Configuration registers
  logic [15:0] sync_word;
  logic [15:0] timeout_ticks;

  // Deframer state
  logic [POS_W-1:0] position;
  hold_t            hold;

  // Step outputs
  logic [POS_W-1:0] position_next;
  hold_t            hold_next;
  res_beat_t        step_beat;
  logic             step_valid;

  // Result register
  logic      res_valid;
  res_beat_t res_beat;

  logic req_acc;

  // Take a request whenever the result register is empty or being drained
  assign req.ready = !res_valid || res.ready;
  assign req_acc   = req.valid && req.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_word     <= SYNC_WORD_RST;
      timeout_ticks <= TIMEOUT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SYNC_WORD:     sync_word     <= cfg_data;
        REG_TIMEOUT_TICKS: timeout_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  spd_frame_step #(
    .BUF_BYTES (BUF_BYTES)
  ) u_step (
    .req_type      (req.req_type),
    .rx_byte       (req.rx_byte),
    .sync_word     (sync_word),
    .timeout_ticks (timeout_ticks),
    .position      (position),
    .hold          (hold),
    .position_next (position_next),
    .hold_next     (hold_next),
    .beat          (step_beat),
    .beat_valid    (step_valid)
  );

  // Advance state only on an accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      position <= '0;
      hold     <= '0;
    end else if (req_acc) begin
      position <= position_next;
      hold     <= hold_next;
    end
  end

  // Load a new result beat, or drop the old one once the receiver takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (req_acc && step_valid) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_acc && step_valid) begin
      res_beat <= step_beat;
    end
  end

  assign res.valid         = res_valid;
  assign res.event_res     = res_beat.event_res;
  assign res.body_byte     = res_beat.body_byte;
  assign res.body_index    = res_beat.body_index;
  assign res.frame_type    = res_beat.frame_type;
  assign res.frame_length  = res_beat.frame_length;
  assign res.frame_address = res_beat.frame_address;

  // Position never reaches the overflow point
  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, position} < OVF_POS))
    else $error("position past overflow point");

  // A produced result always lands in the result register
  a_res_loaded: assert property (@(posedge clk) disable iff (rst)
    (req_acc && step_valid) |=> res.valid)
    else $error("result beat lost");

  // Every frame end returns to hunting with a cleared tick count
  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    (req_acc && step_valid && step_beat.event_res != EV_BODY)
      |=> (position == '0 && hold.tick_count == 16'd0))
    else $error("frame end did not clear state");

  // A byte that ends nothing leaves the tick count alone
  a_byte_no_tick: assert property (@(posedge clk) disable iff (rst)
    (req_acc && req.req_type == REQ_BYTE &&
     !(step_valid && step_beat.event_res != EV_BODY))
      |=> $stable(hold.tick_count))
    else $error("byte changed tick count");

endmodule

### tb/sv/spd_frame_checker.sv
// Deframer checker: predicts result beats from accepted requests and compares them.
module spd_frame_checker
  import spd_pkg::*;
#(
  parameter int BUF_BYTES = BUF_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  spd_req_if                   req,
  spd_res_if                   res,
  output int                   pending,
  output int                   fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int REPORT_MAX = 10;

  logic [15:0] code_reg;
  logic [15:0] tmo_reg;
  int          frame_pos;
  logic [7:0]  type_q;
  logic [15:0] len_q;
  logic [31:0] addr_q;
  logic [15:0] tick_q;

  res_beat_t expected_beats[$];
  int        err_cnt = 0;

  assign fail_count = err_cnt;

  function automatic res_beat_t make_beat(input event_t ev, input logic [7:0] b,
                                          input logic [5:0] i);
    res_beat_t beat;
    beat.event_res     = ev;
    beat.body_byte     = b;
    beat.body_index    = i;
    beat.frame_type    = type_q;
    beat.frame_length  = len_q;
    beat.frame_address = addr_q;
    return beat;
  endfunction

  function automatic void close_frame();
    frame_pos = 0;
    tick_q    = '0;
  endfunction

  // Advance the deframer by one request; return 1 when it yields a beat.
  function automatic bit deframe_step(input logic kind, input logic [7:0] b,
                                      output res_beat_t beat);
    int idx;
    bit got;
    idx  = frame_pos;
    got  = 1'b0;
    beat = '0;
    if (kind == REQ_TICK) begin
      if (tick_q != 16'hFFFF) tick_q = tick_q + 16'd1;
      if (tick_q >= tmo_reg) begin
        beat = make_beat(EV_TIMEOUT, 8'h00, 6'd0);
        close_frame();
        return 1'b1;
      end
      return 1'b0;
    end
    if (idx == POS_HUNT) begin
      if (b != code_reg[15:8]) return 1'b0;
    end else if (idx == POS_CODE_LO) begin
      if (b != code_reg[7:0]) begin
        beat = make_beat(EV_BAD, 8'h00, 6'd0);
        close_frame();
        return 1'b1;
      end
    end else if (idx <= POS_ADDR_LST) begin
      addr_q = {addr_q[23:0], b};
    end else if (idx == POS_TYPE) begin
      type_q = b;
    end else if (idx == POS_LEN_HI) begin
      len_q = {b, 8'h00};
    end else if (idx == POS_LEN_LO) begin
      len_q[7:0] = b;
    end else begin
      if (idx - LEN_OFFSET == int'(len_q)) begin
        beat = make_beat(EV_OK, b, 6'(idx - HEADER_BYTES));
        close_frame();
        return 1'b1;
      end
      beat = make_beat(EV_BODY, b, 6'(idx - HEADER_BYTES));
      got  = 1'b1;
    end
    // overflow replaces whatever this byte produced
    frame_pos = idx + 1;
    if (frame_pos + HEADER_BYTES >= BUF_BYTES) begin
      beat = make_beat(EV_BAD, 8'h00, 6'd0);
      close_frame();
      return 1'b1;
    end
    return got;
  endfunction

  always @(posedge clk) begin
    res_beat_t seen;
    res_beat_t want;
    res_beat_t beat;
    if (rst) begin
      code_reg  = SYNC_WORD_RST;
      tmo_reg   = TIMEOUT_RST;
      frame_pos = 0;
      type_q    = '0;
      len_q     = '0;
      addr_q    = '0;
      tick_q    = '0;
      expected_beats.delete();
    end else begin
      if (res.valid && res.ready) begin
        seen.event_res     = event_t'(res.event_res);
        seen.body_byte     = res.body_byte;
        seen.body_index    = res.body_index;
        seen.frame_type    = res.frame_type;
        seen.frame_length  = res.frame_length;
        seen.frame_address = res.frame_address;
        if (expected_beats.size() == 0) begin
          err_cnt++;
          if (err_cnt <= REPORT_MAX)
            $display("unexpected beat: ev=%0d byte=%02h idx=%0d type=%02h len=%04h addr=%08h",
                     seen.event_res, seen.body_byte, seen.body_index, seen.frame_type,
                     seen.frame_length, seen.frame_address);
        end else begin
          want = expected_beats.pop_front();
          if (seen.event_res !== want.event_res || seen.body_byte !== want.body_byte ||
              seen.body_index !== want.body_index || seen.frame_type !== want.frame_type ||
              seen.frame_length !== want.frame_length ||
              seen.frame_address !== want.frame_address) begin
            err_cnt++;
            if (err_cnt <= REPORT_MAX) begin
              $display("mismatch: exp ev=%0d byte=%02h idx=%0d type=%02h len=%04h addr=%08h",
                       want.event_res, want.body_byte, want.body_index, want.frame_type,
                       want.frame_length, want.frame_address);
              $display("          got ev=%0d byte=%02h idx=%0d type=%02h len=%04h addr=%08h",
                       seen.event_res, seen.body_byte, seen.body_index, seen.frame_type,
                       seen.frame_length, seen.frame_address);
            end
          end
        end
      end
      if (req.valid && req.ready) begin
        if (deframe_step(req.req_type, req.rx_byte, beat)) expected_beats.push_back(beat);
      end
      if (cfg_we) begin
        if (cfg_index == REG_SYNC_WORD) code_reg = cfg_data;
        else if (cfg_index == REG_TIMEOUT_TICKS) tmo_reg = cfg_data;
      end
    end
    pending <= expected_beats.size();
  end

endmodule

### tb/sv/tb_sensor_packet_deframer_unit.sv
// Testbench top of the sensor packet deframer: stimulus, watchdog and verdict.
module tb_sensor_packet_deframer_unit
  import spd_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RAND_ITEMS     = 900;
  localparam int PHASE_ITEMS    = 150;
  localparam int WATCHDOG_LIMIT = 1000;
  // Body bytes that fit before the overflow check fires: the first body byte
  // sits at position 9 and the frame is cut once position + 9 reaches the
  // buffer size, so a length of exactly this many still completes ok.
  localparam int BODY_ROOM = BUF_BYTES_DEF - 2 * HEADER_BYTES;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  spd_req_if req_ch();
  spd_res_if res_ch();

  int          pending;
  int          fail_count;
  int          idle_cycles = 0;
  int          item_count  = 0;
  int          tick_pct    = 0;
  bit          quiet       = 1'b0;
  logic [15:0] cur_code;

  sensor_packet_deframer_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_ch),
    .res       (res_ch)
  );

  spd_frame_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .req        (req_ch),
    .res        (res_ch),
    .pending    (pending),
    .fail_count (fail_count)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Drive one request beat and hold it until the block takes it. Insert a
  // random gap first unless this stretch runs without idling.
  task automatic put_beat(input logic kind, input logic [7:0] b, input bit counted);
    int gap;
    int r;
    gap = 0;
    r   = $urandom_range(0, 99);
    if (!quiet) begin
      if (r < 55) gap = 0;
      else if (r < 88) gap = $urandom_range(1, 3);
      else if (r < 97) gap = $urandom_range(4, 12);
      else gap = $urandom_range(20, 60);
    end
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.req_type <= kind;
    req_ch.rx_byte  <= b;
    do @(posedge clk); while (!req_ch.ready);
    if (counted) item_count++;
  endtask

  // Send a frame header and body, stopping after cut bytes for a broken
  // frame. Sprinkle ticks in between at the phase's tick rate.
  task automatic send_frame(input logic [7:0] lo, input logic [31:0] addr,
                            input logic [7:0] ftype, input logic [15:0] len,
                            input int n_body, input int cut);
    logic [7:0] hdr [HEADER_BYTES];
    hdr = '{cur_code[15:8], lo, addr[31:24], addr[23:16], addr[15:8], addr[7:0],
            ftype, len[15:8], len[7:0]};
    for (int i = 0; i < HEADER_BYTES + n_body && i < cut; i++) begin
      if ($urandom_range(0, 99) < tick_pct) put_beat(REQ_TICK, 8'($urandom), 1'b1);
      put_beat(REQ_BYTE, (i < HEADER_BYTES) ? hdr[i] : 8'($urandom), 1'b1);
    end
  endtask

  // Drop valid and wait until every predicted beat has come out, then let
  // the result register settle in case the last request gave no beat.
  task automatic wait_idle();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_config(input logic [15:0] code, input logic [15:0] tmo);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= REG_SYNC_WORD;
    cfg_data  <= code;
    @(posedge clk);
    cfg_index <= REG_TIMEOUT_TICKS;
    cfg_data  <= tmo;
    @(posedge clk);
    cfg_we   <= 1'b0;
    cur_code  = code;
  endtask

  // Result side: accept in runs, stall at random, mostly briefly.
  initial begin : res_sink
    int n;
    int r;
    do @(posedge clk); while (rst);
    forever begin
      res_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk);
      r = $urandom_range(0, 99);
      if (r < 40) n = 0;
      else if (r < 85) n = $urandom_range(1, 3);
      else if (r < 97) n = $urandom_range(4, 12);
      else n = $urandom_range(30, 80);
      if (n > 0) begin
        res_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
    end
  end

  // End the run when no beat moves on either channel for too long.
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [15:0] code;
    logic [15:0] tmo;
    logic [15:0] len;
    logic [7:0]  lo;
    int          phase;
    int          phase_end;
    int          n_body;
    int          cut;
    int          r;

    rst             <= 1'b1;
    cfg_we          <= 1'b0;
    cfg_index       <= REG_SYNC_WORD;
    cfg_data        <= '0;
    req_ch.valid    <= 1'b0;
    req_ch.req_type <= REQ_BYTE;
    req_ch.rx_byte  <= 8'h00;
    res_ch.ready    <= 1'b0;
    cur_code         = SYNC_WORD_RST;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: hunting drops bytes that are not the high start byte.
    put_beat(REQ_BYTE, 8'h00, 1'b0);
    put_beat(REQ_BYTE, 8'hFF, 1'b0);
    // Wrong low start byte ends the frame as bad.
    put_beat(REQ_BYTE, SYNC_WORD_RST[15:8], 1'b0);
    put_beat(REQ_BYTE, SYNC_WORD_RST[7:0] ^ 8'h03, 1'b0);
    // Complete frame with a two-byte body, then ticks well under the limit.
    send_frame(SYNC_WORD_RST[7:0], 32'hFF00AA55, 8'h80, 16'd2, 2, HEADER_BYTES + 2);
    put_beat(REQ_TICK, 8'h00, 1'b0);
    put_beat(REQ_TICK, 8'hFF, 1'b0);
    // Shortest timeout: a tick while hunting, then one in the middle of a header.
    write_config(16'hFFFF, 16'd1);
    put_beat(REQ_TICK, 8'h5A, 1'b0);
    put_beat(REQ_BYTE, 8'hFF, 1'b0);
    put_beat(REQ_BYTE, 8'hFF, 1'b0);
    put_beat(REQ_BYTE, 8'h12, 1'b0);
    put_beat(REQ_TICK, 8'hA5, 1'b0);

    // Random phases, each under its own configuration.
    phase = 0;
    while (item_count < RAND_ITEMS) begin
      case (phase)
        0: begin
          code = 16'h0000;
          tmo  = 16'hFFFF;
        end
        1: begin
          code = 16'hFFFF;
          tmo  = 16'd2;
        end
        2: begin
          code = SYNC_WORD_RST;
          tmo  = TIMEOUT_RST;
        end
        default: begin
          code = 16'($urandom);
          r    = $urandom_range(0, 3);
          if (r == 0) tmo = 16'($urandom_range(1, 8));
          else if (r == 1) tmo = 16'($urandom_range(9, 60));
          else if (r == 2) tmo = 16'($urandom_range(100, 1000));
          else tmo = 16'hFFFF;
        end
      endcase
      write_config(code, tmo);
      tick_pct  = $urandom_range(0, 12);
      phase_end = item_count + PHASE_ITEMS;

      while (item_count < phase_end && item_count < RAND_ITEMS) begin
        quiet = ($urandom_range(0, 4) == 0);
        // Line noise between frames, mostly dropped by the hunt.
        if ($urandom_range(0, 2) == 0)
          repeat ($urandom_range(1, 3)) put_beat(REQ_BYTE, 8'($urandom), 1'b0);
        // Bare tick bursts so timeouts also land while hunting.
        if ($urandom_range(0, 5) == 0)
          repeat ($urandom_range(1, 5)) put_beat(REQ_TICK, 8'($urandom), 1'b1);

        lo = ($urandom_range(0, 9) == 0) ? 8'($urandom) : cur_code[7:0];
        r  = $urandom_range(0, 99);
        if (r < 8) len = 16'd0;
        else if (r < 60) len = 16'($urandom_range(1, 12));
        else if (r < 80) len = 16'($urandom_range(13, BODY_ROOM - 1));
        else if (r < 86) len = 16'(BODY_ROOM);
        else if (r < 94) len = 16'($urandom_range(BODY_ROOM + 1, 60));
        else len = 16'($urandom);
        // Lengths that cannot complete run the body into the overflow.
        n_body = (len == 0 || len > BODY_ROOM) ? BODY_ROOM : int'(len);
        cut    = HEADER_BYTES + n_body;
        if ($urandom_range(0, 9) == 0) cut = $urandom_range(1, cut - 1);
        send_frame(lo, 32'($urandom), 8'($urandom), len, n_body, cut);
      end
      phase++;
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### sensor_packet_deframer_unit.f
hdl/spd_pkg.sv
hdl/spd_if.sv
hdl/spd_frame_step.sv
hdl/sensor_packet_deframer_unit.sv
tb/sv/spd_frame_checker.sv
tb/sv/tb_sensor_packet_deframer_unit.sv
